// File: src/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg: shared types and constants for the peer trust table
// Operation and status codes, table geometry, controller/datapath links.
// ----------------------------------------------------------------------------
package ptt_pkg;
    localparam int MAX_ENTRIES = 8;
    localparam int SLOT_W      = 3;
    localparam int CNT_W       = 4;
    localparam int ROUTE_W     = 4;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_FORGET = 3'd1;
    localparam logic [2:0] OP_FMAC   = 3'd2;
    localparam logic [2:0] OP_FKEY   = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_DUP  = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic              load;      // capture the input word
        logic              scan_clr;  // reset scan pointer and flags
        logic              scan_step; // examine one slot
        logic              do_add;    // append the record
        logic              do_move;   // move last entry into hit slot
        logic              emit;      // drive result for one cycle
        logic [1:0]        status;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] op;
        logic       scan_done;
        logic       hit;
        logic       full;
        logic       read_ok;
    } t_stat;
endpackage

// File: src/peer_trust_table.sv
// ----------------------------------------------------------------------------
// peer_trust_table: associative table of up to 8 peer records
// Lookup by MAC or key, read by slot, add with route id allocation, forget.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the operation word onto the i_ ports and raise start while busy is
//   low; the word is taken at that edge and busy rises.
//   The controller clears the scan state, then walks the used slots one per
//   cycle (key or MAC compare, by operation, and route id usage gathered in the
//   same pass), stopping early on the first match.
//   One result word is shown for exactly one cycle with o_valid high;
//   busy falls in that same cycle boundary, so a new start may follow.
//   The slot scan is what sets how long a word takes. One word is handled at
//   a time: the next start is taken at the edge that ends the result cycle.
//   Add and forget write back in the report cycle (append, or move the last
//   entry into the freed slot).
//   Reset (synchronous, i_rst_n low) empties the table; stored records are
//   not cleared, only slots below the count are ever read.
//   The receiver cannot stall: o_valid words must be taken when shown.
// ----------------------------------------------------------------------------
module peer_trust_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_operation,
    input  logic [47:0] i_peer_mac,
    input  logic [63:0] i_key_word0,
    input  logic [63:0] i_key_word1,
    input  logic [63:0] i_key_word2,
    input  logic [63:0] i_key_word3,
    input  logic [15:0] i_requested_route_id,
    input  logic [2:0]  i_slot_index,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [2:0]  o_found_slot,
    output logic [3:0]  o_found_route_id,
    output logic [47:0] o_found_mac,
    output logic [63:0] o_found_key0,
    output logic [63:0] o_found_key1,
    output logic [63:0] o_found_key2,
    output logic [63:0] o_found_key3
);
    import ptt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ptt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_stat(stat), .o_cmd(cmd)
    );

    ptt_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_operation(i_operation), .i_peer_mac(i_peer_mac),
        .i_key_word0(i_key_word0), .i_key_word1(i_key_word1),
        .i_key_word2(i_key_word2), .i_key_word3(i_key_word3),
        .i_requested_route_id(i_requested_route_id),
        .i_slot_index(i_slot_index),
        .o_valid(o_valid), .o_status(o_status), .o_found_slot(o_found_slot),
        .o_found_route_id(o_found_route_id), .o_found_mac(o_found_mac),
        .o_found_key0(o_found_key0), .o_found_key1(o_found_key1),
        .o_found_key2(o_found_key2), .o_found_key3(o_found_key3)
    );
endmodule

// File: src/ptt_datapath.sv
// ----------------------------------------------------------------------------
// ptt_datapath: record store, one-slot-per-cycle scanner, id allocator
// ----------------------------------------------------------------------------
module ptt_datapath (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ptt_pkg::t_cmd           i_cmd,
    output ptt_pkg::t_stat          o_stat,
    input  logic [2:0]              i_operation,
    input  logic [47:0]             i_peer_mac,
    input  logic [63:0]             i_key_word0,
    input  logic [63:0]             i_key_word1,
    input  logic [63:0]             i_key_word2,
    input  logic [63:0]             i_key_word3,
    input  logic [15:0]             i_requested_route_id,
    input  logic [2:0]              i_slot_index,
    output logic                    o_valid,
    output logic [1:0]              o_status,
    output logic [2:0]              o_found_slot,
    output logic [3:0]              o_found_route_id,
    output logic [47:0]             o_found_mac,
    output logic [63:0]             o_found_key0,
    output logic [63:0]             o_found_key1,
    output logic [63:0]             o_found_key2,
    output logic [63:0]             o_found_key3
);
    import ptt_pkg::*;

    logic [47:0]        r_mac   [MAX_ENTRIES];
    logic [63:0]        r_k0    [MAX_ENTRIES];
    logic [63:0]        r_k1    [MAX_ENTRIES];
    logic [63:0]        r_k2    [MAX_ENTRIES];
    logic [63:0]        r_k3    [MAX_ENTRIES];
    logic [ROUTE_W-1:0] r_route [MAX_ENTRIES];
    logic [CNT_W-1:0]   r_count;

    logic [2:0]         r_op;
    logic [47:0]        r_in_mac;
    logic [63:0]        r_in_k0, r_in_k1, r_in_k2, r_in_k3;
    logic [15:0]        r_req;
    logic [SLOT_W-1:0]  r_in_slot;

    logic [CNT_W-1:0]   r_ptr;
    logic               r_hit;
    logic [SLOT_W-1:0]  r_hit_slot;
    logic [MAX_ENTRIES:1] r_used;

    logic [SLOT_W-1:0]  ptr_s, res_slot, last_s, cnt_s;
    logic               key_eq, mac_eq, scan_done;
    logic [ROUTE_W-1:0] new_id, low_id;
    logic               req_ok;

    assign ptr_s     = r_ptr[SLOT_W-1:0];
    assign cnt_s     = r_count[SLOT_W-1:0];
    assign last_s    = SLOT_W'(r_count - 1'b1);
    assign scan_done = (r_ptr >= r_count) || r_hit;
    assign key_eq    = r_k0[ptr_s] == r_in_k0 && r_k1[ptr_s] == r_in_k1 &&
                       r_k2[ptr_s] == r_in_k2 && r_k3[ptr_s] == r_in_k3;
    assign mac_eq    = r_mac[ptr_s] == r_in_mac;

    assign req_ok = r_req >= 16'd1 && r_req <= 16'(MAX_ENTRIES) &&
                    !r_used[r_req[ROUTE_W-1:0]];
    always_comb begin
        low_id = '0;
        for (int i = MAX_ENTRIES; i >= 1; i--) begin
            if (!r_used[i]) low_id = ROUTE_W'(i);
        end
        new_id = req_ok ? r_req[ROUTE_W-1:0] : low_id;
    end

    assign res_slot = (r_op == OP_READ) ? r_in_slot :
                      (r_op == OP_ADD)  ? cnt_s : r_hit_slot;

    assign o_stat.op        = r_op;
    assign o_stat.scan_done = scan_done;
    assign o_stat.hit       = r_hit;
    assign o_stat.full      = r_count >= CNT_W'(MAX_ENTRIES);
    assign o_stat.read_ok   = {1'b0, r_in_slot} < r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit;
            if (i_cmd.do_add) r_count <= r_count + 1'b1;
            if (i_cmd.do_move) r_count <= r_count - 1'b1;
        end
        if (i_cmd.load) begin
            r_op <= i_operation;       r_in_mac <= i_peer_mac;
            r_in_k0 <= i_key_word0;    r_in_k1 <= i_key_word1;
            r_in_k2 <= i_key_word2;    r_in_k3 <= i_key_word3;
            r_req <= i_requested_route_id; r_in_slot <= i_slot_index;
        end
        if (i_cmd.scan_clr) begin
            r_ptr <= '0; r_hit <= 1'b0; r_hit_slot <= '0; r_used <= '0;
        end else if (i_cmd.scan_step && !scan_done) begin
            r_ptr <= r_ptr + 1'b1;
            if (r_route[ptr_s] >= ROUTE_W'(1) &&
                r_route[ptr_s] <= ROUTE_W'(MAX_ENTRIES))
                r_used[r_route[ptr_s]] <= 1'b1;
            if ((r_op == OP_FMAC) ? mac_eq : key_eq) begin
                r_hit <= 1'b1; r_hit_slot <= ptr_s;
            end
        end
        if (i_cmd.emit) begin
            o_status <= i_cmd.status;
            if (i_cmd.status == ST_OK) begin
                o_found_slot     <= res_slot;
                o_found_route_id <= (r_op == OP_ADD) ? new_id : r_route[res_slot];
                o_found_mac      <= (r_op == OP_ADD) ? r_in_mac : r_mac[res_slot];
                o_found_key0     <= (r_op == OP_ADD) ? r_in_k0 : r_k0[res_slot];
                o_found_key1     <= (r_op == OP_ADD) ? r_in_k1 : r_k1[res_slot];
                o_found_key2     <= (r_op == OP_ADD) ? r_in_k2 : r_k2[res_slot];
                o_found_key3     <= (r_op == OP_ADD) ? r_in_k3 : r_k3[res_slot];
            end else begin
                o_found_slot <= '0; o_found_route_id <= '0; o_found_mac <= '0;
                o_found_key0 <= '0; o_found_key1 <= '0;
                o_found_key2 <= '0; o_found_key3 <= '0;
            end
        end
        if (i_cmd.do_add) begin
            r_mac[cnt_s] <= r_in_mac; r_k0[cnt_s] <= r_in_k0;
            r_k1[cnt_s] <= r_in_k1;   r_k2[cnt_s] <= r_in_k2;
            r_k3[cnt_s] <= r_in_k3;   r_route[cnt_s] <= new_id;
        end
        if (i_cmd.do_move) begin
            r_mac[r_hit_slot] <= r_mac[last_s]; r_k0[r_hit_slot] <= r_k0[last_s];
            r_k1[r_hit_slot] <= r_k1[last_s];   r_k2[r_hit_slot] <= r_k2[last_s];
            r_k3[r_hit_slot] <= r_k3[last_s];   r_route[r_hit_slot] <= r_route[last_s];
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES)) else $error("count overflow");
    a_add_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_add |-> r_count < CNT_W'(MAX_ENTRIES)) else $error("add when full");
    a_move_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_move |-> r_hit) else $error("move without hit");
`endif
endmodule

// File: src/ptt_ctrl.sv
// ----------------------------------------------------------------------------
// ptt_ctrl: sequencer for load, scan, decide, write-back and report
// ----------------------------------------------------------------------------
module ptt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  ptt_pkg::t_stat i_stat,
    output ptt_pkg::t_cmd  o_cmd
);
    import ptt_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_CLR, S_SCAN, S_DONE} t_state;
    t_state r_state;

    always_comb begin
        o_cmd = '0;
        o_cmd.load     = start && r_state == S_IDLE;
        o_cmd.scan_clr = r_state == S_CLR;
        o_cmd.scan_step = r_state == S_SCAN;
        o_cmd.status = ST_MISS;
        if (r_state == S_DONE) begin
            o_cmd.emit = 1'b1;
            unique case (i_stat.op)
                OP_ADD: begin
                    if (i_stat.full) o_cmd.status = ST_FULL;
                    else if (i_stat.hit) o_cmd.status = ST_DUP;
                    else begin o_cmd.status = ST_OK; o_cmd.do_add = 1'b1; end
                end
                OP_FORGET: if (i_stat.hit) begin
                    o_cmd.status = ST_OK; o_cmd.do_move = 1'b1;
                end
                OP_FMAC, OP_FKEY: if (i_stat.hit) o_cmd.status = ST_OK;
                OP_READ: if (i_stat.read_ok) o_cmd.status = ST_OK;
                default: o_cmd.status = ST_MISS;
            endcase
        end
    end

    assign busy = r_state != S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (start) r_state <= S_CLR;
                S_CLR:  r_state <= S_SCAN;
                S_SCAN: if (i_stat.scan_done) r_state <= S_DONE;
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_emit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> !o_cmd.emit) else $error("double emit");
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.do_add && o_cmd.do_move)) else $error("add and move together");
    a_start_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_cmd.scan_clr) else $error("no scan clear");
`endif
endmodule

// File: test/tb_peer_trust_table.sv
// ----------------------------------------------------------------------------
// tb_peer_trust_table: self-checking bench for the peer trust table
// Directed table of operations, then random traffic biased toward a small
// key/MAC pool so adds, duplicates, hits, forgets and a full table all occur.
// Every result word is checked against a behavioral table model.
// ----------------------------------------------------------------------------
module tb_peer_trust_table;
    import ptt_pkg::*;

    localparam int WDOG_LIMIT = 2000;
    localparam int N_RAND     = 750;

    // one table record
    typedef struct {
        logic [47:0] mac;
        logic [63:0] key [4];
        logic [3:0]  route;
    } t_peer_rec;

    // one input word
    typedef struct {
        logic [2:0]  op;
        logic [47:0] mac;
        logic [63:0] key [4];
        logic [15:0] req;
        logic [2:0]  slot;
    } t_peer_cmd;

    // one result word
    typedef struct {
        logic [1:0]  status;
        logic [2:0]  slot;
        logic [3:0]  route;
        logic [47:0] mac;
        logic [63:0] key [4];
    } t_peer_resp;

    // directed row: command plus optional typed-in status
    typedef struct {
        t_peer_cmd  cmd;
        bit         fixed;
        logic [1:0] status;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_operation;
    logic [47:0] i_peer_mac;
    logic [63:0] i_key_word0, i_key_word1, i_key_word2, i_key_word3;
    logic [15:0] i_requested_route_id;
    logic [2:0]  i_slot_index;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [2:0]  o_found_slot;
    logic [3:0]  o_found_route_id;
    logic [47:0] o_found_mac;
    logic [63:0] o_found_key0, o_found_key1, o_found_key2, o_found_key3;

    peer_trust_table dut (.*);

    // model copy of the table
    t_peer_rec  table_q [$];
    t_peer_resp pending_resp [$];
    int         mismatches;
    int         idle_cycles;
    bit         timed_out;

    // small pools so random traffic keeps hitting stored entries
    logic [47:0] mac_pool [4];
    logic [63:0] key_pool [4][4];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_peer_resp miss_resp(logic [1:0] st);
        t_peer_resp r;
        r.status = st;
        r.slot   = '0;
        r.route  = '0;
        r.mac    = '0;
        for (int w = 0; w < 4; w++) r.key[w] = '0;
        return r;
    endfunction

    function automatic t_peer_resp entry_resp(int s);
        t_peer_resp r;
        r.status = ST_OK;
        r.slot   = s[2:0];
        r.route  = table_q[s].route;
        r.mac    = table_q[s].mac;
        for (int w = 0; w < 4; w++) r.key[w] = table_q[s].key[w];
        return r;
    endfunction

    function automatic int key_slot(t_peer_cmd c);
        for (int s = 0; s < table_q.size(); s++)
            if (table_q[s].key == c.key) return s;
        return -1;
    endfunction

    // table behavior: result word for one command, updates table_q
    function automatic t_peer_resp table_step(t_peer_cmd c);
        t_peer_resp r;
        t_peer_rec  rec;
        bit         used [MAX_ENTRIES+1];
        int         hit;
        int         id;
        r = miss_resp(ST_MISS);
        case (c.op)
            OP_ADD: begin
                if (table_q.size() >= MAX_ENTRIES) begin
                    r = miss_resp(ST_FULL);
                end else if (key_slot(c) >= 0) begin
                    r = miss_resp(ST_DUP);
                end else begin
                    for (int i = 0; i <= MAX_ENTRIES; i++) used[i] = 1'b0;
                    foreach (table_q[s])
                        if (table_q[s].route >= 1 && table_q[s].route <= MAX_ENTRIES)
                            used[table_q[s].route] = 1'b1;
                    id = 0;
                    if (c.req >= 1 && c.req <= MAX_ENTRIES && !used[c.req]) begin
                        id = c.req;
                    end else begin
                        for (int i = MAX_ENTRIES; i >= 1; i--)
                            if (!used[i]) id = i;
                    end
                    rec.mac   = c.mac;
                    rec.key   = c.key;
                    rec.route = id[3:0];
                    table_q.push_back(rec);
                    r = entry_resp(table_q.size() - 1);
                end
            end
            OP_FORGET: begin
                hit = key_slot(c);
                if (hit >= 0) begin
                    r = entry_resp(hit);
                    table_q[hit] = table_q[table_q.size()-1];
                    void'(table_q.pop_back());
                end
            end
            OP_FMAC: begin
                for (int s = 0; s < table_q.size(); s++)
                    if (table_q[s].mac == c.mac) begin
                        r = entry_resp(s);
                        break;
                    end
            end
            OP_FKEY: begin
                hit = key_slot(c);
                if (hit >= 0) r = entry_resp(hit);
            end
            OP_READ: begin
                if (c.slot < table_q.size()) r = entry_resp(c.slot);
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_peer_cmd pool_cmd(logic [2:0] op, int k, logic [15:0] req);
        t_peer_cmd c;
        c.op  = op;
        c.mac = mac_pool[k];
        c.key = key_pool[k];
        c.req = req;
        c.slot = 3'($urandom_range(0, 7));
        return c;
    endfunction

    function automatic t_peer_cmd rand_cmd();
        t_peer_cmd c;
        int        pick;
        int        k;
        pick = $urandom_range(0, 99);
        k    = $urandom_range(0, 3);
        c    = pool_cmd(OP_ADD, k, 16'($urandom_range(0, 10)));
        // fresh keys so the table can fill
        if ($urandom_range(0, 1)) begin
            for (int w = 0; w < 4; w++) c.key[w] = {$urandom, $urandom};
            c.mac = 48'({$urandom, $urandom});
        end
        if ($urandom_range(0, 9) == 0) c.req = 16'($urandom);
        if (pick < 35)       c.op = OP_ADD;
        else if (pick < 55)  c.op = OP_FORGET;
        else if (pick < 68)  c.op = OP_FMAC;
        else if (pick < 81)  c.op = OP_FKEY;
        else if (pick < 95)  c.op = OP_READ;
        else                 c.op = 3'($urandom_range(5, 7));
        // look up an entry that is really stored most of the time
        if (c.op != OP_ADD && table_q.size() > 0 && $urandom_range(0, 3) != 0) begin
            k = $urandom_range(0, table_q.size() - 1);
            c.mac = table_q[k].mac;
            c.key = table_q[k].key;
        end
        return c;
    endfunction

    // start stays high after an accept until the next word or its idle gap
    task automatic send_word(t_peer_cmd c);
        int gap;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_operation          <= c.op;
        i_peer_mac           <= c.mac;
        i_key_word0          <= c.key[0];
        i_key_word1          <= c.key[1];
        i_key_word2          <= c.key[2];
        i_key_word3          <= c.key[3];
        i_requested_route_id <= c.req;
        i_slot_index         <= c.slot;
        start                <= 1'b1;
        // accepted at the first edge with busy low
        do @(posedge i_clk); while (busy);
        pending_resp.push_back(table_step(c));
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_peer_resp e;
        bit         bad;
        if (i_rst_n && o_valid) begin
            if (pending_resp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word, status %0d", o_status);
            end else begin
                e   = pending_resp.pop_front();
                bad = (o_status !== e.status) || (o_found_slot !== e.slot) ||
                      (o_found_route_id !== e.route) || (o_found_mac !== e.mac) ||
                      (o_found_key0 !== e.key[0]) || (o_found_key1 !== e.key[1]) ||
                      (o_found_key2 !== e.key[2]) || (o_found_key3 !== e.key[3]);
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp st %0d slot %0d rt %0d mac %h keys %h %h %h %h",
                                 e.status, e.slot, e.route, e.mac,
                                 e.key[0], e.key[1], e.key[2], e.key[3]);
                        $display("          got st %0d slot %0d rt %0d mac %h keys %h %h %h %h",
                                 o_status, o_found_slot, o_found_route_id, o_found_mac,
                                 o_found_key0, o_found_key1, o_found_key2, o_found_key3);
                    end
                end
            end
        end
    end

    // watchdog: cycles with no word accepted on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT && !timed_out) begin
            timed_out <= 1'b1;
            $display("peer_trust_table test failed");
            $finish;
        end
    end

    t_dir_row dir_rows [$];

    task automatic add_row(t_peer_cmd c, bit fixed, logic [1:0] st);
        t_dir_row r;
        r.cmd    = c;
        r.fixed  = fixed;
        r.status = st;
        dir_rows.push_back(r);
    endtask

    initial begin
        t_peer_cmd c;
        mismatches = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        start = 1'b0;
        i_rst_n = 1'b0;
        i_operation = '0;
        i_peer_mac = '0;
        i_key_word0 = '0;
        i_key_word1 = '0;
        i_key_word2 = '0;
        i_key_word3 = '0;
        i_requested_route_id = '0;
        i_slot_index = '0;
        // extremes in the pool: all zeros and all ones
        mac_pool[0] = '0;
        mac_pool[1] = '1;
        for (int w = 0; w < 4; w++) begin
            key_pool[0][w] = '0;
            key_pool[1][w] = '1;
        end
        for (int k = 2; k < 4; k++) begin
            mac_pool[k] = 48'({$urandom, $urandom});
            for (int w = 0; w < 4; w++) key_pool[k][w] = {$urandom, $urandom};
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table; status typed in where obvious
        add_row(pool_cmd(OP_READ, 0, 0), 1, ST_MISS);       // empty table
        add_row(pool_cmd(OP_FKEY, 0, 0), 1, ST_MISS);
        add_row(pool_cmd(OP_FMAC, 0, 0), 1, ST_MISS);
        add_row(pool_cmd(OP_FORGET, 0, 0), 1, ST_MISS);
        add_row(pool_cmd(OP_ADD, 0, 16'd8), 1, ST_OK);      // top in-range id
        add_row(pool_cmd(OP_ADD, 0, 16'd1), 1, ST_DUP);     // duplicate key
        add_row(pool_cmd(OP_ADD, 1, 16'hFFFF), 0, ST_OK);   // out-of-range id
        add_row(pool_cmd(OP_ADD, 2, 16'd8), 0, ST_OK);      // id in use
        add_row(pool_cmd(OP_ADD, 3, 16'd0), 0, ST_OK);      // no id asked
        add_row(pool_cmd(OP_FMAC, 1, 0), 0, ST_OK);
        add_row(pool_cmd(OP_FKEY, 2, 0), 0, ST_OK);
        c = pool_cmd(OP_READ, 0, 0);
        c.slot = 3'd7;
        add_row(c, 1, ST_MISS);                             // slot past count
        c.slot = 3'd0;
        add_row(c, 0, ST_OK);
        c = pool_cmd(3'd7, 1, 0);
        add_row(c, 1, ST_MISS);                             // unknown op
        add_row(pool_cmd(OP_FORGET, 0, 0), 0, ST_OK);       // last moves down
        for (int k = 0; k < 5; k++) begin                   // fill the table
            c = pool_cmd(OP_ADD, 0, 16'(k + 1));
            c.key[0] = 64'(k + 100);
            add_row(c, 0, ST_OK);
        end
        c.key[0] = 64'd999;
        add_row(c, 0, ST_OK);
        add_row(c, 1, ST_FULL);                              // full table
        c = pool_cmd(OP_READ, 0, 0);
        c.slot = 3'd7;
        add_row(c, 0, ST_OK);

        foreach (dir_rows[i]) begin
            send_word(dir_rows[i].cmd);
            if (dir_rows[i].fixed && pending_resp[$].status !== dir_rows[i].status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("row %0d: model status %0d, table says %0d", i,
                             pending_resp[$].status, dir_rows[i].status);
            end
        end

        for (int n = 0; n < N_RAND; n++) send_word(rand_cmd());
        start <= 1'b0;

        while (pending_resp.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_resp.size() == 0)
            $display("peer_trust_table test passed");
        else
            $display("peer_trust_table test failed");
        $finish;
    end
endmodule
